/* hw/rtl/beacon_header_signature_detector_assert.svh */
// Assertion macros for the beacon header signature detector.
`ifndef BEACON_HEADER_SIGNATURE_DETECTOR_ASSERT_SVH
`define BEACON_HEADER_SIGNATURE_DETECTOR_ASSERT_SVH

// Assert that a implies b at the next clock.
`define BHSD_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed");

// Assert that a implies b at the same clock.
`define BHSD_ASSERT_SAME(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed");

`endif

/* hw/rtl/bhsd_pkg.sv */
`default_nettype none
package bhsd_pkg;
  localparam int unsigned MaxBoundaries = 32;
  localparam int unsigned HeadDepth = 21;
  localparam int unsigned MinPayload = 23;
  localparam int unsigned LenScan = 14;
  localparam logic [15:0] ZlibMark = 16'h789c;
  localparam logic [7:0] PrintLo = 8'd33;
  localparam logic [7:0] PrintHi = 8'd126;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    PATH_LEN = 2'd0,
    PATH_Z19 = 2'd1,
    PATH_Z16 = 2'd2,
    PATH_NONE = 2'd3
  } path_e;

  typedef struct packed {
    logic [HeadDepth*8-1:0] head;
    logic [15:0] expect_len;
    logic gate_ok;
  } verdict_job_t;

  typedef struct packed {
    logic detected;
    logic [3:0] length_offset;
    path_e match_path;
    logic [3:0] flag_offset;
  } verdict_t;
endpackage
`default_nettype wire

/* hw/rtl/bhsd_front.sv */
`default_nettype none
module bhsd_front import bhsd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic accept_i,
  input  wire logic mode_i,
  input  wire logic [15:0] boundary_len_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic is_first_i,
  input  wire logic is_last_i,
  input  wire logic is_tcp_i,
  input  wire logic both_directions_payload_i,
  output logic job_valid_o,
  output verdict_job_t job_o
);
  logic [7:0] head_q [HeadDepth];
  logic [15:0] count_q, count_d, first_len_q, first_len_d, second_len_q, second_len_d;
  logic [5:0] bcount_q, bcount_d;
  logic done_q, done_d;
  logic [15:0] cnt_base, fl_base, sl_base, new_count, exp0;
  logic [5:0] bc_base;
  logic done_base;

  always_comb begin
    cnt_base = (is_first_i) ? 16'd0 : count_q;
    new_count = (cnt_base == 16'hffff) ? cnt_base : cnt_base + 16'd1;
    fl_base = is_first_i ? 16'd0 : first_len_q;
    sl_base = is_first_i ? 16'd0 : second_len_q;
    bc_base = is_first_i ? 6'd0 : bcount_q;
    done_base = is_first_i ? 1'b0 : done_q;
    count_d = count_q;
    first_len_d = first_len_q;
    second_len_d = second_len_q;
    bcount_d = bcount_q;
    done_d = done_q;
    if (accept_i && !mode_i) begin
      first_len_d = fl_base;
      second_len_d = sl_base;
      bcount_d = bc_base;
      done_d = done_base;
      if (!done_base && (bc_base < 6'(MaxBoundaries))) begin
        bcount_d = bc_base + 6'd1;
        if (boundary_len_i != 16'd0) begin
          if (fl_base == 16'd0) begin
            first_len_d = boundary_len_i;
          end else begin
            second_len_d = boundary_len_i;
            done_d = 1'b1;
          end
        end
      end
    end else if (accept_i) begin
      count_d = new_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      first_len_q <= '0;
      second_len_q <= '0;
      bcount_q <= '0;
      done_q <= 1'b0;
      for (int k = 0; k < HeadDepth; k++) head_q[k] <= '0;
    end else begin
      count_q <= count_d;
      first_len_q <= first_len_d;
      second_len_q <= second_len_d;
      bcount_q <= bcount_d;
      done_q <= done_d;
      if (accept_i && mode_i) begin
        for (int k = 0; k < HeadDepth; k++) begin
          if (cnt_base == 16'(k)) head_q[k] <= data_byte_i;
          else if (is_first_i) head_q[k] <= '0;
        end
      end
    end
  end

  always_comb begin
    exp0 = (first_len_q != 16'd0) ? first_len_q : new_count;
    job_valid_o = accept_i && mode_i && is_last_i;
    for (int k = 0; k < HeadDepth; k++) begin
      if (cnt_base == 16'(k)) job_o.head[k*8 +: 8] = data_byte_i;
      else if (is_first_i) job_o.head[k*8 +: 8] = '0;
      else job_o.head[k*8 +: 8] = head_q[k];
    end
    job_o.expect_len = (second_len_q == exp0) ? exp0 + 16'd1 : exp0;
    job_o.gate_ok = is_tcp_i && both_directions_payload_i &&
                    (new_count >= 16'(MinPayload));
  end
endmodule
`default_nettype wire

/* hw/rtl/bhsd_queue.sv */
`default_nettype none
module bhsd_queue import bhsd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  verdict_job_t data_i,
  output logic full_o,
  output logic valid_o,
  input  wire logic pop_i,
  output verdict_job_t data_o
);
  verdict_job_t mem_q [QueueDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o = (cnt_q == 2'(QueueDepth));
  assign valid_o = (cnt_q != 2'd0);
  assign data_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/bhsd_back.sv */
`default_nettype none
module bhsd_back import bhsd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  input  verdict_job_t job_i,
  output logic job_pop_o,
  output logic valid_o,
  input  wire logic stall_i,
  output verdict_t res_o
);
  verdict_t res_d, res_q;
  logic valid_q;
  logic [31:0] w;
  logic found, anchor, at_zero, p0, p4, p8;
  logic [3:0] off;

  function automatic logic [7:0] hb(input logic [HeadDepth*8-1:0] h, input int unsigned i);
    hb = h[i*8 +: 8];
  endfunction

  function automatic logic prn(input logic [HeadDepth*8-1:0] h, input int unsigned s);
    logic ok;
    ok = 1'b1;
    for (int unsigned k = 0; k < 5; k++)
      if (hb(h, s + k) < PrintLo || hb(h, s + k) > PrintHi) ok = 1'b0;
    prn = ok;
  endfunction

  always_comb begin
    found = 1'b0;
    off = 4'(LenScan);
    for (int unsigned i = 0; i < LenScan; i++) begin
      w = {hb(job_i.head, i+3), hb(job_i.head, i+2), hb(job_i.head, i+1), hb(job_i.head, i)};
      if (!found && w == {16'd0, job_i.expect_len}) begin
        found = 1'b1;
        off = 4'(i);
      end
    end
    p0 = prn(job_i.head, 0);
    p4 = prn(job_i.head, 4);
    p8 = prn(job_i.head, 8);
    res_d.detected = 1'b0;
    res_d.length_offset = 4'(LenScan);
    res_d.match_path = PATH_NONE;
    res_d.flag_offset = 4'd0;
    anchor = 1'b0;
    at_zero = 1'b0;
    if (job_i.gate_ok) begin
      if (found) begin
        res_d.length_offset = off;
        res_d.match_path = PATH_LEN;
        anchor = 1'b1;
        at_zero = (off == 4'd0);
      end else if ({hb(job_i.head, 19), hb(job_i.head, 20)} == ZlibMark) begin
        res_d.match_path = PATH_Z19;
        anchor = 1'b1;
        at_zero = 1'b1;
      end else if ({hb(job_i.head, 16), hb(job_i.head, 17)} == ZlibMark) begin
        res_d.match_path = PATH_Z16;
        anchor = 1'b1;
      end
      if (anchor && at_zero && p4) begin
        res_d.detected = 1'b1;
        res_d.flag_offset = 4'd4;
      end else if (anchor && at_zero && p8) begin
        res_d.detected = 1'b1;
        res_d.flag_offset = 4'd8;
      end else if (anchor && !at_zero && p0) begin
        res_d.detected = 1'b1;
      end
    end
  end

  assign job_pop_o = job_valid_i && (!valid_q || !stall_i);
  assign valid_o = valid_q;
  assign res_o = res_q;

  always_ff @(posedge clk_i) begin
    if (job_pop_o) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (job_pop_o) begin
      valid_q <= 1'b1;
    end else if (!stall_i) begin
      valid_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/beacon_header_signature_detector.sv */
// Beacon header signature detector.
// Input channel: in_valid_i / in_stall_o carry boundary entries (mode 0)
// and payload bytes (mode 1), one per cycle while in_stall_o is low.
// Output channel: out_valid_o / out_stall_i carry one verdict per payload
// transaction that has is_last set; other transactions give none.
// The front stage updates boundary and payload state on each accepted
// transaction and forms a verdict job on the last byte. A two-entry queue
// feeds the back stage, which runs the length, zlib and flag comparisons
// into an output register. With nothing stalled, the last byte's verdict
// job is written into the queue and then into the output register, which
// drives out_valid_o.
// Reset clears control state, not queue or verdict data; in_stall_o is low.
// A stalled receiver holds the verdict; the queue absorbs two more verdict
// jobs, then in_stall_o rises until the back stage drains.
`default_nettype none
module beacon_header_signature_detector import bhsd_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic in_stall_o,
  input  wire logic mode_i,
  input  wire logic [15:0] boundary_len_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic is_first_i,
  input  wire logic is_last_i,
  input  wire logic is_tcp_i,
  input  wire logic both_directions_payload_i,
  output logic out_valid_o,
  input  wire logic out_stall_i,
  output logic detected_o,
  output logic [3:0] length_offset_o,
  output logic [1:0] match_path_o,
  output logic [3:0] flag_offset_o
);
  logic accept, job_valid, q_full, q_valid, q_pop;
  verdict_job_t job, q_job;
  verdict_t res;

  assign in_stall_o = q_full;
  assign accept = in_valid_i && !q_full;

  bhsd_front u_front (
    .clk_i, .rst_ni, .accept_i(accept), .mode_i, .boundary_len_i, .data_byte_i,
    .is_first_i, .is_last_i, .is_tcp_i, .both_directions_payload_i,
    .job_valid_o(job_valid), .job_o(job)
  );

  bhsd_queue u_queue (
    .clk_i, .rst_ni, .push_i(job_valid), .data_i(job), .full_o(q_full),
    .valid_o(q_valid), .pop_i(q_pop), .data_o(q_job)
  );

  bhsd_back u_back (
    .clk_i, .rst_ni, .job_valid_i(q_valid), .job_i(q_job), .job_pop_o(q_pop),
    .valid_o(out_valid_o), .stall_i(out_stall_i), .res_o(res)
  );

  assign detected_o = res.detected;
  assign length_offset_o = res.length_offset;
  assign match_path_o = res.match_path;
  assign flag_offset_o = res.flag_offset;
endmodule
`default_nettype wire

/* hw/rtl/bhsd_checker.sv */
`default_nettype none
`include "beacon_header_signature_detector_assert.svh"
module bhsd_checker import bhsd_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic detected_o,
  input wire logic [3:0] length_offset_o,
  input wire logic [1:0] match_path_o,
  input wire logic [3:0] flag_offset_o
);
  `BHSD_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_valid_i && in_stall_o, in_valid_i)
  `BHSD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `BHSD_ASSERT_SAME(a_det_anchor, clk_i, rst_ni, out_valid_o && detected_o,
                    match_path_o != PATH_NONE)
  `BHSD_ASSERT_SAME(a_path_off, clk_i, rst_ni, out_valid_o && match_path_o != PATH_LEN,
                    length_offset_o == 4'(LenScan))
  `BHSD_ASSERT_SAME(a_flag_zero, clk_i, rst_ni, out_valid_o && !detected_o,
                    flag_offset_o == 4'd0)
endmodule

bind beacon_header_signature_detector bhsd_checker u_bhsd_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
  .detected_o, .length_offset_o, .match_path_o, .flag_offset_o
);
`default_nettype wire

/* bench/beacon_header_signature_detector_tb.sv */
`timescale 1ns / 1ps
module beacon_header_signature_detector_tb;
  import bhsd_pkg::*;

  class verdict_scoreboard;
    logic [7:0]  head [HeadDepth];
    logic [15:0] byte_cnt;
    logic [15:0] first_len;
    logic [15:0] second_len;
    logic [5:0]  bnd_cnt;
    logic        bnd_done;
    verdict_t    pending[$];
    int          errors;

    function new();
      foreach (head[k]) head[k] = '0;
      byte_cnt = '0; first_len = '0; second_len = '0; bnd_cnt = '0; bnd_done = 0;
      errors = 0;
    endfunction

    function bit printable_at(int s);
      for (int k = 0; k < 5; k++)
        if (head[s+k] < PrintLo || head[s+k] > PrintHi) return 0;
      return 1;
    endfunction

    function void note_transaction(logic m, logic [15:0] bl, logic [7:0] db, logic f,
                                   logic l, logic tcp, logic both);
      verdict_t v;
      logic [15:0] want;
      logic [31:0] w;
      bit anchor, at_zero;
      if (!m) begin
        if (f) begin
          first_len = 0; second_len = 0; bnd_cnt = 0; bnd_done = 0;
        end
        if (!bnd_done && bnd_cnt < MaxBoundaries) begin
          bnd_cnt++;
          if (bl != 0) begin
            if (first_len == 0) first_len = bl;
            else begin
              second_len = bl; bnd_done = 1;
            end
          end
        end
        return;
      end
      if (f) begin
        foreach (head[k]) head[k] = '0;
        byte_cnt = 0;
      end
      if (byte_cnt < HeadDepth) head[byte_cnt] = db;
      if (byte_cnt != 16'hffff) byte_cnt++;
      if (!l) return;
      v = '{1'b0, 4'(LenScan), PATH_NONE, 4'd0};
      anchor = 0; at_zero = 0;
      if (tcp && both && byte_cnt >= MinPayload) begin
        want = (first_len != 0) ? first_len : byte_cnt;
        if (second_len == want) want = want + 16'd1;
        for (int i = 0; i < LenScan; i++) begin
          w = {head[i+3], head[i+2], head[i+1], head[i]};
          if (!anchor && w == {16'd0, want}) begin
            v.length_offset = 4'(i); v.match_path = PATH_LEN; anchor = 1;
            at_zero = (i == 0);
          end
        end
        if (!anchor) begin
          if ({head[19], head[20]} == ZlibMark) begin
            v.match_path = PATH_Z19; anchor = 1; at_zero = 1;
          end else if ({head[16], head[17]} == ZlibMark) begin
            v.match_path = PATH_Z16; anchor = 1;
          end
        end
        if (anchor) begin
          if (at_zero) begin
            if (printable_at(4)) begin
              v.detected = 1; v.flag_offset = 4'd4;
            end else if (printable_at(8)) begin
              v.detected = 1; v.flag_offset = 4'd8;
            end
          end else if (printable_at(0)) begin
            v.detected = 1;
          end
        end
      end
      pending.push_back(v);
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected verdict %p", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.detected !== e.detected) begin
        $display("%0t detected exp %0d got %0d", $time, e.detected, got.detected); errors++;
      end
      if (got.length_offset !== e.length_offset) begin
        $display("%0t length_offset exp %0d got %0d", $time, e.length_offset,
                 got.length_offset); errors++;
      end
      if (got.match_path !== e.match_path) begin
        $display("%0t match_path exp %0d got %0d", $time, e.match_path, got.match_path);
        errors++;
      end
      if (got.flag_offset !== e.flag_offset) begin
        $display("%0t flag_offset exp %0d got %0d", $time, e.flag_offset, got.flag_offset);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, in_stall_o, mode_i = 0, is_first_i = 0, is_last_i = 0;
  logic is_tcp_i = 0, both_directions_payload_i = 0;
  logic [15:0] boundary_len_i = 0;
  logic [7:0] data_byte_i = 0;
  logic out_valid_o, out_stall_i = 0, detected_o;
  logic [3:0] length_offset_o, flag_offset_o;
  logic [1:0] match_path_o;

  verdict_scoreboard sb = new();
  int hold_off = 0;
  int send_gap_max = 3;

  beacon_header_signature_detector dut (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_verdict('{detected_o, length_offset_o, path_e'(match_path_o), flag_offset_o});
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  task automatic send_item(logic m, logic [15:0] bl, logic [7:0] db, logic f, logic l,
                           logic tcp, logic both);
    int gap = (send_gap_max > 0 && $urandom_range(0, 4) == 0) ?
              $urandom_range(1, send_gap_max) : 0;
    repeat (gap) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1; mode_i <= m; boundary_len_i <= bl; data_byte_i <= db;
    is_first_i <= f; is_last_i <= l; is_tcp_i <= tcp; both_directions_payload_i <= both;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_transaction(m, bl, db, f, l, tcp, both);
  endtask

  task automatic send_flow(logic [7:0] pay[], logic [15:0] bnd[], logic tcp, logic both);
    foreach (bnd[k])
      send_item(1'b0, bnd[k], 8'($urandom), k == 0, 1'($urandom), 1'($urandom),
                1'($urandom));
    foreach (pay[k])
      send_item(1'b1, 16'($urandom), pay[k], k == 0, k == pay.size() - 1, tcp, both);
  endtask

  task automatic random_flow(int style);
    logic [7:0] pay[];
    logic [15:0] bnd[];
    int n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : $urandom_range(21, 32);
    int nb = $urandom_range(0, 5);
    logic [15:0] len;
    int off;
    pay = new[n];
    bnd = new[nb];
    foreach (pay[k])
      pay[k] = 8'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(33, 126));
    foreach (bnd[k]) bnd[k] = $urandom_range(0, 2) == 0 ? 16'd0 :
                              16'($urandom_range(0, 1) ? $urandom : $urandom_range(20, 40));
    len = (nb > 0 && bnd[0] != 0) ? bnd[0] : 16'(n);
    if (nb > 1 && bnd[1] == len && $urandom_range(0, 1)) len++;
    case (style)
      0: begin
        off = $urandom_range(0, LenScan - 1);
        if (off + 3 < n) begin
          pay[off] = len[7:0]; pay[off+1] = len[15:8]; pay[off+2] = 0; pay[off+3] = 0;
        end
      end
      1: if (n > 20) begin
        pay[19] = ZlibMark[15:8]; pay[20] = ZlibMark[7:0];
      end
      2: if (n > 17) begin
        pay[16] = ZlibMark[15:8]; pay[17] = ZlibMark[7:0];
      end
      default: ;
    endcase
    send_flow(pay, bnd, $urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0);
  endtask

  task automatic wait_drained();
    int guard = 0;
    while (sb.pending.size() != 0 && guard < 100000) begin
      in_valid_i <= 0;
      @(posedge clk_i);
      guard++;
    end
    in_valid_i <= 0;
    repeat (10) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] pay[];
    logic [15:0] bnd[];
    int sent;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    pay = new[23];
    foreach (pay[k]) pay[k] = 8'd65;
    pay[0] = 23; pay[1] = 0; pay[2] = 0; pay[3] = 0;
    bnd = new[0];
    send_flow(pay, bnd, 1, 1);
    pay[0] = 8'd255; pay[1] = 8'd255; pay[2] = 0; pay[3] = 0; pay[4] = 8'd33;
    pay[8] = 8'd126;
    bnd = new[3];
    bnd[0] = 0; bnd[1] = 16'hffff; bnd[2] = 16'hffff;
    send_flow(pay, bnd, 1, 1);
    pay[0] = 0; pay[1] = 0;
    pay[19] = 8'h78; pay[20] = 8'h9c;
    send_flow(pay, bnd, 1, 1);
    pay[19] = 0; pay[16] = 8'h78; pay[17] = 8'h9c; pay[0] = 8'd32;
    send_flow(pay, bnd, 1, 1);
    send_flow(pay, bnd, 0, 1);
    send_flow(pay, bnd, 1, 0);
    pay = new[22];
    foreach (pay[k]) pay[k] = 8'd255;
    send_flow(pay, bnd, 1, 1);
    bnd = new[40];
    foreach (bnd[k]) bnd[k] = 0;
    bnd[35] = 16'd7;
    send_flow(pay, bnd, 1, 1);
    sent = 0;
    while (sent < 1400) begin
      if (sent > 500 && sent < 560) begin
        if (sent <= 530) hold_off <= 300;
        send_gap_max = 0;
      end else begin
        send_gap_max = $urandom_range(0, 1) ? 0 : 6;
      end
      random_flow($urandom_range(0, 3));
      sent += 30;
      if (sent > 900 && sent <= 930) wait_drained();
    end
    wait_drained();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end
endmodule
